// ===== hw/rtl/fbrb_pkg.sv =====
package fbrb_pkg;

   localparam int DEF_SCREEN_WIDTH  = 1024;
   localparam int DEF_SCREEN_HEIGHT = 768;
   localparam int DEF_CONTROL_DEPTH = 64;

   localparam int ADDR_W     = 21;
   localparam int CTRL_IDX_W = 6;
   localparam int PAL_IDX_W  = 8;
   localparam int PAL_DEPTH  = 256;
   localparam int COLOR_W    = 24;

   localparam logic [ADDR_W-1:0] ROM_END    = 21'h000100;
   localparam logic [ADDR_W-1:0] CTRL_BASE  = 21'h003000;
   localparam int                CTRL_LIMIT = 'h3100;
   localparam logic [ADDR_W-1:0] PAL_BASE   = 21'h004000;
   localparam logic [ADDR_W-1:0] PAL_LIMIT  = 21'h004400;

   localparam logic [31:0] MAGIC_WORD       = 32'h0c007ca1;
   localparam logic [31:0] DEVICE_SIGNATURE = 32'h4b494e36;
   localparam logic [63:0] NAME_LO          = 64'h6266776f_6e6e696b;
   localparam logic [15:0] NAME_HI          = 16'h382c;
   localparam logic [31:0] FEATURE_BITS     = 32'h00000001;
   localparam int          FEATURE_IDX      = 8;

   typedef enum logic [1:0] {
      OP_READ   = 2'd0,
      OP_WRITE  = 2'd1,
      OP_LOOKUP = 2'd2
   } opcode_type;

   typedef enum logic [1:0] {
      SIZE_1 = 2'd0,
      SIZE_2 = 2'd1,
      SIZE_4 = 2'd2,
      SIZE_8 = 2'd3
   } size_type;

   typedef struct packed {
      logic                  err;
      logic                  rom_rd;
      logic                  ctrl_rd;
      logic                  ctrl_wr;
      logic                  pal_wr;
      logic                  lookup;
      logic [CTRL_IDX_W-1:0] ctrl_index;
      logic [PAL_IDX_W-1:0]  pal_index;
      logic [63:0]           rom_data;
   } decode_type;

   // identification ROM, one byte per offset, zero beyond the name field
   function automatic logic [7:0] rom_byte(input logic [7:0] a);
      logic [7:0] r;
      r = 8'h00;
      if (a < 8'd4) begin
         r = MAGIC_WORD[{a[1:0], 3'b000} +: 8];
      end else if (a < 8'd8) begin
         r = DEVICE_SIGNATURE[{a[1:0], 3'b000} +: 8];
      end else if (a < 8'd16) begin
         r = NAME_LO[{a[2:0], 3'b000} +: 8];
      end else if (a < 8'd18) begin
         r = NAME_HI[{a[0], 3'b000} +: 8];
      end
      return r;
   endfunction

endpackage

// ===== hw/rtl/framebuffer_register_bank.sv =====
// Control-register bank of an 8-bit indexed framebuffer: identification ROM,
// control words and a write-only palette with a scanout lookup port. One item
// is taken per clock cycle; busy is high only while reset is held. Each item
// yields exactly one result, on the rsp_ ports for a single cycle marked by
// rsp_valid; the item passes through the input register and then through the
// control-word or palette memory read port into the result register. Results
// cannot be held off, so the receiver must take every strobe as it comes.
// Writes take effect for the very next item.
module framebuffer_register_bank #(
   parameter int SCREEN_WIDTH  = fbrb_pkg::DEF_SCREEN_WIDTH,
   parameter int SCREEN_HEIGHT = fbrb_pkg::DEF_SCREEN_HEIGHT,
   parameter int CONTROL_DEPTH = fbrb_pkg::DEF_CONTROL_DEPTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [1:0]                      req_opcode,
   input  logic [fbrb_pkg::ADDR_W-1:0]     req_address,
   input  logic [1:0]                      req_size_log2,
   input  logic [31:0]                     req_write_data,
   input  logic [fbrb_pkg::PAL_IDX_W-1:0]  req_pixel_index,
   output logic                            rsp_valid,
   output logic [63:0]                     rsp_read_data,
   output logic                            rsp_status,
   output logic [fbrb_pkg::COLOR_W-1:0]    rsp_pixel_color,
   output logic                            rsp_redraw_request
);

   logic                           req_valid_ff;
   logic [1:0]                     req_opcode_ff;
   logic [fbrb_pkg::ADDR_W-1:0]    req_address_ff;
   logic [1:0]                     req_size_log2_ff;
   logic [31:0]                    req_write_data_ff;
   logic [fbrb_pkg::PAL_IDX_W-1:0] req_pixel_index_ff;

   logic                           rsp_valid_ff;
   logic                           rsp_status_ff;
   logic                           rsp_sel_ctrl_ff;
   logic                           rsp_sel_pal_ff;
   logic                           rsp_redraw_ff;
   logic [63:0]                    rsp_rom_ff;

   fbrb_pkg::decode_type           dec;
   logic [31:0]                    ctrl_rdata;
   logic [fbrb_pkg::COLOR_W-1:0]   pal_color;
   logic                           accept;

   assign busy   = reset;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= accept;
      end
      if (accept) begin
         req_opcode_ff      <= req_opcode;
         req_address_ff     <= req_address;
         req_size_log2_ff   <= req_size_log2;
         req_write_data_ff  <= req_write_data;
         req_pixel_index_ff <= req_pixel_index;
      end
   end

   fbrb_decode #(
      .CONTROL_DEPTH(CONTROL_DEPTH)
   ) u_decode (
      .opcode    (req_opcode_ff),
      .address   (req_address_ff),
      .size_log2 (req_size_log2_ff),
      .dec       (dec)
   );

   fbrb_ctrl_regs #(
      .SCREEN_WIDTH (SCREEN_WIDTH),
      .SCREEN_HEIGHT(SCREEN_HEIGHT),
      .CONTROL_DEPTH(CONTROL_DEPTH)
   ) u_ctrl_regs (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (req_valid_ff && dec.ctrl_wr),
      .index   (dec.ctrl_index),
      .wr_data (req_write_data_ff),
      .rd_data (ctrl_rdata)
   );

   fbrb_palette u_palette (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (req_valid_ff && dec.pal_wr),
      .wr_index (dec.pal_index),
      .wr_data  (req_write_data_ff[fbrb_pkg::COLOR_W-1:0]),
      .rd_index (req_pixel_index_ff),
      .rd_color (pal_color)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= req_valid_ff;
      end
      rsp_status_ff   <= dec.err;
      rsp_sel_ctrl_ff <= dec.ctrl_rd;
      rsp_sel_pal_ff  <= dec.lookup;
      rsp_redraw_ff   <= dec.pal_wr;
      rsp_rom_ff      <= dec.rom_data;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_read_data      = rsp_sel_ctrl_ff ? {32'h0, ctrl_rdata} : rsp_rom_ff;
   assign rsp_pixel_color    = rsp_sel_pal_ff ? pal_color : '0;
   assign rsp_redraw_request = rsp_redraw_ff;

   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |=> ##1 rsp_valid)
      else $error("result strobe missing two cycles after accept");

   a_err_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status) |->
         (rsp_read_data == 64'h0 && rsp_pixel_color == '0 && !rsp_redraw_request))
      else $error("error result carries data");

   a_one_kind: assert property (@(posedge clock) disable iff (reset)
      req_valid_ff |-> $onehot0({dec.rom_rd, dec.ctrl_rd, dec.ctrl_wr, dec.pal_wr,
                                 dec.lookup}))
      else $error("decode selects more than one target");

   a_err_excl: assert property (@(posedge clock) disable iff (reset)
      (req_valid_ff && dec.err) |->
         !(dec.rom_rd || dec.ctrl_rd || dec.ctrl_wr || dec.pal_wr || dec.lookup))
      else $error("failed access still selects a target");

endmodule

// ===== hw/rtl/fbrb_decode.sv =====
module fbrb_decode #(
   parameter int CONTROL_DEPTH = fbrb_pkg::DEF_CONTROL_DEPTH
) (
   input  logic [1:0]                    opcode,
   input  logic [fbrb_pkg::ADDR_W-1:0]   address,
   input  logic [1:0]                    size_log2,
   output fbrb_pkg::decode_type          dec
);

   localparam int CtrlEndRaw = 'h3000 + 4 * CONTROL_DEPTH;
   localparam int CtrlEnd    = (CtrlEndRaw > fbrb_pkg::CTRL_LIMIT) ?
                               fbrb_pkg::CTRL_LIMIT : CtrlEndRaw;

   logic [3:0]                  nbytes;
   logic [3:0]                  mask;
   logic                        aligned;
   logic                        word_size;
   logic                        in_rom;
   logic                        ctrl_hit;
   logic                        pal_hit;
   logic [fbrb_pkg::ADDR_W-1:0] ctrl_off;
   logic [63:0]                 rom_bytes;

   assign nbytes    = 4'd1 << size_log2;
   assign mask      = nbytes - 4'd1;
   assign aligned   = (address[2:0] & mask[2:0]) == 3'b000;
   assign word_size = size_log2 == fbrb_pkg::SIZE_4;
   assign in_rom    = address < fbrb_pkg::ROM_END;
   assign ctrl_hit  = (address >= fbrb_pkg::CTRL_BASE) &&
                      (address < fbrb_pkg::ADDR_W'(CtrlEnd));
   assign pal_hit   = (address >= fbrb_pkg::PAL_BASE) && (address < fbrb_pkg::PAL_LIMIT);
   assign ctrl_off  = address - fbrb_pkg::CTRL_BASE;

   // gather up to eight ROM bytes little-endian, lanes past the size stay zero
   always_comb begin
      rom_bytes = '0;
      for (int k = 0; k < 8; k++) begin
         if (4'(k) < nbytes) begin
            rom_bytes[8*k +: 8] = fbrb_pkg::rom_byte(address[7:0] + 8'(k));
         end
      end
   end

   always_comb begin
      dec            = '0;
      dec.err        = 1'b1;
      dec.ctrl_index = ctrl_off[fbrb_pkg::CTRL_IDX_W+1:2];
      dec.pal_index  = address[fbrb_pkg::PAL_IDX_W+1:2];
      unique case (opcode)
         fbrb_pkg::OP_READ: begin
            if (aligned && in_rom) begin
               dec.err      = 1'b0;
               dec.rom_rd   = 1'b1;
               dec.rom_data = rom_bytes;
            end else if (aligned && word_size && ctrl_hit) begin
               dec.err     = 1'b0;
               dec.ctrl_rd = 1'b1;
            end
         end
         fbrb_pkg::OP_WRITE: begin
            if (aligned && word_size && ctrl_hit) begin
               dec.err     = 1'b0;
               dec.ctrl_wr = 1'b1;
            end else if (aligned && word_size && pal_hit) begin
               dec.err    = 1'b0;
               dec.pal_wr = 1'b1;
            end
         end
         fbrb_pkg::OP_LOOKUP: begin
            dec.err    = 1'b0;
            dec.lookup = 1'b1;
         end
         default: begin
            dec.err = 1'b1;
         end
      endcase
   end

endmodule

// ===== hw/rtl/fbrb_ctrl_regs.sv =====
module fbrb_ctrl_regs #(
   parameter int SCREEN_WIDTH  = fbrb_pkg::DEF_SCREEN_WIDTH,
   parameter int SCREEN_HEIGHT = fbrb_pkg::DEF_SCREEN_HEIGHT,
   parameter int CONTROL_DEPTH = fbrb_pkg::DEF_CONTROL_DEPTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            wr_en,
   input  logic [fbrb_pkg::CTRL_IDX_W-1:0] index,
   input  logic [31:0]                     wr_data,
   output logic [31:0]                     rd_data
);

   localparam int          IdxW     = $clog2(CONTROL_DEPTH);
   localparam logic [31:0] SizeWord = 32'((SCREEN_HEIGHT << 12) | SCREEN_WIDTH);
   localparam logic [31:0] VramWord = 32'(SCREEN_WIDTH * SCREEN_HEIGHT);

   logic [31:0]              mem_ff [CONTROL_DEPTH];
   logic [CONTROL_DEPTH-1:0] vld_ff;
   logic [31:0]              rd_mem_ff;
   logic                     rd_vld_ff;
   logic [31:0]              rd_dflt_ff;
   logic [IdxW-1:0]          idx;
   logic [31:0]              dflt;

   assign idx = index[IdxW-1:0];

   // reset contents of the word, used until the word is first written
   always_comb begin
      if (idx == IdxW'(0)) begin
         dflt = SizeWord;
      end else if (idx == IdxW'(1)) begin
         dflt = VramWord;
      end else if (idx == IdxW'(fbrb_pkg::FEATURE_IDX)) begin
         dflt = fbrb_pkg::FEATURE_BITS;
      end else begin
         dflt = 32'h0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[idx] <= wr_data;
      end
      rd_mem_ff  <= mem_ff[idx];
      rd_dflt_ff <= dflt;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            vld_ff[idx] <= 1'b1;
         end
         rd_vld_ff <= vld_ff[idx];
      end
   end

   assign rd_data = rd_vld_ff ? rd_mem_ff : rd_dflt_ff;

endmodule

// ===== hw/rtl/fbrb_palette.sv =====
module fbrb_palette (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           wr_en,
   input  logic [fbrb_pkg::PAL_IDX_W-1:0] wr_index,
   input  logic [fbrb_pkg::COLOR_W-1:0]   wr_data,
   input  logic [fbrb_pkg::PAL_IDX_W-1:0] rd_index,
   output logic [fbrb_pkg::COLOR_W-1:0]   rd_color
);

   logic [fbrb_pkg::COLOR_W-1:0]   mem_ff [fbrb_pkg::PAL_DEPTH];
   logic [fbrb_pkg::PAL_DEPTH-1:0] vld_ff;
   logic [fbrb_pkg::COLOR_W-1:0]   rd_mem_ff;
   logic                           rd_vld_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_index] <= wr_data;
      end
      rd_mem_ff <= mem_ff[rd_index];
   end

   // entry never written reads as black
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            vld_ff[wr_index] <= 1'b1;
         end
         rd_vld_ff <= vld_ff[rd_index];
      end
   end

   assign rd_color = rd_vld_ff ? rd_mem_ff : '0;

endmodule

// ===== verif/tb_framebuffer_register_bank.sv =====
module tb_framebuffer_register_bank;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] OP_UNUSED  = 2'd3;
   localparam logic       ST_OK      = 1'b0;
   localparam logic       ST_ERR     = 1'b1;
   localparam int         CTRL_WORDS = fbrb_pkg::DEF_CONTROL_DEPTH;
   localparam int         CTRL_END   =
      (int'(fbrb_pkg::CTRL_BASE) + 4 * CTRL_WORDS > fbrb_pkg::CTRL_LIMIT) ?
      fbrb_pkg::CTRL_LIMIT : int'(fbrb_pkg::CTRL_BASE) + 4 * CTRL_WORDS;
   localparam int         RANDOM_ITEMS = 950;
   localparam int         CALM_TAIL    = 150;
   localparam int         CYCLE_LIMIT  = 200000;

   // identification bytes, offset 0 in the low byte; everything above is zero
   localparam logic [8*24-1:0] ID_ROM_IMAGE =
      192'h000000000000_382c_6266776f6e6e696b_4b494e36_0c007ca1;

   typedef struct packed {
      logic [1:0]                   opcode;
      logic [fbrb_pkg::ADDR_W-1:0]  address;
      logic [1:0]                   size_log2;
      logic [31:0]                  write_data;
      logic [7:0]                   pixel_index;
   } bank_access_type;

   typedef struct packed {
      logic [63:0]                  read_data;
      logic                         status;
      logic [fbrb_pkg::COLOR_W-1:0] pixel_color;
      logic                         redraw_request;
   } bank_response_type;

   typedef struct packed {
      bank_access_type   access;
      logic              typed;
      bank_response_type response;
   } access_row_type;

   logic                           clock;
   logic                           reset;
   logic                           start;
   logic                           busy;
   logic [1:0]                     req_opcode;
   logic [fbrb_pkg::ADDR_W-1:0]    req_address;
   logic [1:0]                     req_size_log2;
   logic [31:0]                    req_write_data;
   logic [fbrb_pkg::PAL_IDX_W-1:0] req_pixel_index;
   logic                           rsp_valid;
   logic [63:0]                    rsp_read_data;
   logic                           rsp_status;
   logic [fbrb_pkg::COLOR_W-1:0]   rsp_pixel_color;
   logic                           rsp_redraw_request;

   // typed-in response that travels with a directed item
   logic                           row_typed;
   bank_response_type              row_response;

   logic [31:0]                    ctrl_words_shadow [CTRL_WORDS];
   logic [fbrb_pkg::COLOR_W-1:0]   palette_shadow [fbrb_pkg::PAL_DEPTH];
   bank_response_type              bank_responses_due [$];
   access_row_type                 directed_rows [$];
   int                             mismatch_count = 0;
   int                             cycle_count = 0;

   framebuffer_register_bank dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_opcode         (req_opcode),
      .req_address        (req_address),
      .req_size_log2      (req_size_log2),
      .req_write_data     (req_write_data),
      .req_pixel_index    (req_pixel_index),
      .rsp_valid          (rsp_valid),
      .rsp_read_data      (rsp_read_data),
      .rsp_status         (rsp_status),
      .rsp_pixel_color    (rsp_pixel_color),
      .rsp_redraw_request (rsp_redraw_request)
   );

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   function automatic logic [7:0] id_rom_byte(input int offset);
      return (offset < 24) ? ID_ROM_IMAGE[8*offset +: 8] : 8'h00;
   endfunction

   // apply one access to the shadow state and return the bank's response
   function automatic bank_response_type bank_response_of(input bank_access_type a);
      bank_response_type r;
      int                nbytes;
      int                addr;
      logic              aligned;
      r = '0;
      r.status = ST_ERR;
      nbytes = 1 << a.size_log2;
      addr = int'(a.address);
      aligned = (addr % nbytes) == 0;
      case (a.opcode)
         fbrb_pkg::OP_READ: begin
            if (aligned && addr < int'(fbrb_pkg::ROM_END)) begin
               for (int k = 0; k < nbytes; k++)
                  r.read_data[8*k +: 8] = id_rom_byte(addr + k);
               r.status = ST_OK;
            end else if (aligned && a.size_log2 == fbrb_pkg::SIZE_4 &&
                         addr >= int'(fbrb_pkg::CTRL_BASE) && addr < CTRL_END) begin
               r.read_data = {32'h0,
                              ctrl_words_shadow[(addr - int'(fbrb_pkg::CTRL_BASE)) >> 2]};
               r.status = ST_OK;
            end
         end
         fbrb_pkg::OP_WRITE: begin
            if (aligned && a.size_log2 == fbrb_pkg::SIZE_4) begin
               if (addr >= int'(fbrb_pkg::CTRL_BASE) && addr < CTRL_END) begin
                  ctrl_words_shadow[(addr - int'(fbrb_pkg::CTRL_BASE)) >> 2] = a.write_data;
                  r.status = ST_OK;
               end else if (addr >= int'(fbrb_pkg::PAL_BASE) &&
                            addr < int'(fbrb_pkg::PAL_LIMIT)) begin
                  palette_shadow[((addr - int'(fbrb_pkg::PAL_BASE)) >> 2) & 8'hff] =
                     a.write_data[23:0];
                  r.status = ST_OK;
                  r.redraw_request = 1'b1;
               end
            end
         end
         fbrb_pkg::OP_LOOKUP: begin
            r.pixel_color = palette_shadow[a.pixel_index];
            r.status = ST_OK;
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic report_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
      if (got !== want) begin
         mismatch_count++;
         $display("%0t %s: expected %h actual %h", $realtime, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      bank_response_type predicted;
      bank_response_type due;
      if (!reset && start && !busy) begin
         predicted = bank_response_of({req_opcode, req_address, req_size_log2,
                                       req_write_data, req_pixel_index});
         bank_responses_due.push_back(row_typed ? row_response : predicted);
      end
      if (rsp_valid) begin
         if (bank_responses_due.size() == 0) begin
            mismatch_count++;
            $display("%0t response with nothing outstanding: expected none actual %h",
                     $realtime, rsp_read_data);
         end else begin
            due = bank_responses_due.pop_front();
            report_field("read_data", due.read_data, rsp_read_data);
            report_field("status", 64'(due.status), 64'(rsp_status));
            report_field("pixel_color", 64'(due.pixel_color), 64'(rsp_pixel_color));
            report_field("redraw_request", 64'(due.redraw_request),
                         64'(rsp_redraw_request));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic add_row(input logic [1:0] op, input logic [fbrb_pkg::ADDR_W-1:0] addr,
                          input logic [1:0] size, input logic [31:0] wdata,
                          input logic [7:0] pix, input logic typed,
                          input logic [63:0] rdata, input logic status,
                          input logic [fbrb_pkg::COLOR_W-1:0] color, input logic redraw);
      access_row_type row;
      row.access = {op, addr, size, wdata, pix};
      row.typed = typed;
      row.response = {rdata, status, color, redraw};
      directed_rows.push_back(row);
   endtask

   // hold start low for the idle cycles, then present the item until taken
   task automatic send_access(input bank_access_type a, input logic typed,
                              input bank_response_type r, input int idle);
      repeat (idle) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      start           <= 1'b1;
      req_opcode      <= a.opcode;
      req_address     <= a.address;
      req_size_log2   <= a.size_log2;
      req_write_data  <= a.write_data;
      req_pixel_index <= a.pixel_index;
      row_typed       <= typed;
      row_response    <= r;
      @(posedge clock);
      while (busy)
         @(posedge clock);
   endtask

   initial begin
      bank_access_type a;
      int              pick;
      int              idle;
      int              sz;
      int              boundary;
      reset           = 1'b1;
      start           = 1'b0;
      req_opcode      = fbrb_pkg::OP_READ;
      req_address     = '0;
      req_size_log2   = fbrb_pkg::SIZE_1;
      req_write_data  = '0;
      req_pixel_index = '0;
      row_typed       = 1'b0;
      row_response    = '0;
      foreach (ctrl_words_shadow[i])
         ctrl_words_shadow[i] = 32'h0;
      foreach (palette_shadow[i])
         palette_shadow[i] = '0;
      ctrl_words_shadow[0] = (fbrb_pkg::DEF_SCREEN_HEIGHT << 12) | fbrb_pkg::DEF_SCREEN_WIDTH;
      ctrl_words_shadow[1] = fbrb_pkg::DEF_SCREEN_WIDTH * fbrb_pkg::DEF_SCREEN_HEIGHT;
      ctrl_words_shadow[fbrb_pkg::FEATURE_IDX] = fbrb_pkg::FEATURE_BITS;

      //      op, address, size, write data, pix, typed
      //      read data, status, color, redraw
      add_row(fbrb_pkg::OP_READ, 21'h000000, fbrb_pkg::SIZE_8, 32'h00000000, 8'h00, 1'b1,
              64'h4b494e36_0c007ca1, ST_OK, 24'h0, 1'b0);
      add_row(fbrb_pkg::OP_READ, 21'h000008, fbrb_pkg::SIZE_8, 32'h00000000, 8'h00, 1'b1,
              64'h6266776f_6e6e696b, ST_OK, 24'h0, 1'b0);
      add_row(fbrb_pkg::OP_READ, 21'h000010, fbrb_pkg::SIZE_4, 32'h00000000, 8'h00, 1'b1,
              64'h0000382c, ST_OK, 24'h0, 1'b0);
      add_row(fbrb_pkg::OP_READ, 21'h000000, fbrb_pkg::SIZE_1, 32'h00000000, 8'h00, 1'b1,
              64'ha1, ST_OK, 24'h0, 1'b0);
      add_row(fbrb_pkg::OP_READ, 21'h000002, fbrb_pkg::SIZE_2, 32'h00000000, 8'h00, 1'b1,
              64'h0c00, ST_OK, 24'h0, 1'b0);
      add_row(fbrb_pkg::OP_READ, 21'h0000f8, fbrb_pkg::SIZE_8, 32'h00000000, 8'h00, 1'b1,
              64'h0, ST_OK, 24'h0, 1'b0);
      add_row(fbrb_pkg::OP_READ, 21'h003000, fbrb_pkg::SIZE_4, 32'h00000000, 8'h00, 1'b1,
              64'h00300400, ST_OK, 24'h0, 1'b0);
      add_row(fbrb_pkg::OP_READ, 21'h003004, fbrb_pkg::SIZE_4, 32'h00000000, 8'h00, 1'b1,
              64'h000c0000, ST_OK, 24'h0, 1'b0);
      add_row(fbrb_pkg::OP_READ, 21'h003020, fbrb_pkg::SIZE_4, 32'h00000000, 8'h00, 1'b1,
              64'h1, ST_OK, 24'h0, 1'b0);
      add_row(fbrb_pkg::OP_READ, 21'h0030fc, fbrb_pkg::SIZE_4, 32'h00000000, 8'h00, 1'b1,
              64'h0, ST_OK, 24'h0, 1'b0);
      // past the control window, misaligned, wrong size, palette read, far top
      add_row(fbrb_pkg::OP_READ, 21'h003100, fbrb_pkg::SIZE_4, 32'h00000000, 8'h00, 1'b1,
              64'h0, ST_ERR, 24'h0, 1'b0);
      add_row(fbrb_pkg::OP_READ, 21'h003002, fbrb_pkg::SIZE_4, 32'h00000000, 8'h00, 1'b1,
              64'h0, ST_ERR, 24'h0, 1'b0);
      add_row(fbrb_pkg::OP_READ, 21'h003000, fbrb_pkg::SIZE_8, 32'h00000000, 8'h00, 1'b1,
              64'h0, ST_ERR, 24'h0, 1'b0);
      add_row(fbrb_pkg::OP_READ, 21'h004000, fbrb_pkg::SIZE_4, 32'h00000000, 8'h00, 1'b1,
              64'h0, ST_ERR, 24'h0, 1'b0);
      add_row(fbrb_pkg::OP_READ, 21'h17ffff, fbrb_pkg::SIZE_1, 32'h00000000, 8'h00, 1'b1,
              64'h0, ST_ERR, 24'h0, 1'b0);
      add_row(fbrb_pkg::OP_WRITE, 21'h003010, fbrb_pkg::SIZE_4, 32'hffffffff, 8'h00, 1'b1,
              64'h0, ST_OK, 24'h0, 1'b0);
      add_row(fbrb_pkg::OP_READ, 21'h003010, fbrb_pkg::SIZE_4, 32'h00000000, 8'h00, 1'b1,
              64'hffffffff, ST_OK, 24'h0, 1'b0);
      add_row(fbrb_pkg::OP_WRITE, 21'h004000, fbrb_pkg::SIZE_4, 32'hffffffff, 8'h00, 1'b1,
              64'h0, ST_OK, 24'h0, 1'b1);
      add_row(fbrb_pkg::OP_LOOKUP, 21'h000000, fbrb_pkg::SIZE_1, 32'h00000000, 8'h00, 1'b1,
              64'h0, ST_OK, 24'hffffff, 1'b0);
      add_row(fbrb_pkg::OP_WRITE, 21'h0043fc, fbrb_pkg::SIZE_4, 32'h5aa5c3e7, 8'h00, 1'b0,
              64'h0, ST_OK, 24'h0, 1'b0);
      add_row(fbrb_pkg::OP_LOOKUP, 21'h1fffff, fbrb_pkg::SIZE_8, 32'hffffffff, 8'hff, 1'b0,
              64'h0, ST_OK, 24'h0, 1'b0);
      add_row(fbrb_pkg::OP_WRITE, 21'h003000, fbrb_pkg::SIZE_2, 32'h12345678, 8'h00, 1'b1,
              64'h0, ST_ERR, 24'h0, 1'b0);
      add_row(fbrb_pkg::OP_WRITE, 21'h004400, fbrb_pkg::SIZE_4, 32'h12345678, 8'h00, 1'b1,
              64'h0, ST_ERR, 24'h0, 1'b0);
      add_row(fbrb_pkg::OP_WRITE, 21'h000000, fbrb_pkg::SIZE_4, 32'h12345678, 8'h00, 1'b1,
              64'h0, ST_ERR, 24'h0, 1'b0);
      add_row(OP_UNUSED, 21'h003000, fbrb_pkg::SIZE_4, 32'hffffffff, 8'hff, 1'b1,
              64'h0, ST_ERR, 24'h0, 1'b0);

      repeat (8)
         @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         idle = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
         send_access(directed_rows[i].access, directed_rows[i].typed,
                     directed_rows[i].response, idle);
      end

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         a.opcode = fbrb_pkg::OP_READ;
         a.size_log2 = fbrb_pkg::SIZE_4;
         a.write_data = $urandom;
         a.pixel_index = 8'($urandom_range(0, 255));
         pick = $urandom_range(0, 99);
         if (pick < 25) begin
            a.address = fbrb_pkg::ADDR_W'(int'(fbrb_pkg::CTRL_BASE) +
                                          4 * $urandom_range(0, CTRL_WORDS - 1));
         end else if (pick < 45) begin
            a.opcode = fbrb_pkg::OP_WRITE;
            a.address = fbrb_pkg::ADDR_W'(int'(fbrb_pkg::CTRL_BASE) +
                                          4 * $urandom_range(0, CTRL_WORDS - 1));
         end else if (pick < 60) begin
            a.opcode = fbrb_pkg::OP_WRITE;
            a.address = fbrb_pkg::ADDR_W'(int'(fbrb_pkg::PAL_BASE) +
                                          4 * $urandom_range(0, fbrb_pkg::PAL_DEPTH - 1));
         end else if (pick < 80) begin
            a.opcode = fbrb_pkg::OP_LOOKUP;
         end else if (pick < 88) begin
            sz = $urandom_range(0, 3);
            a.size_log2 = 2'(sz);
            a.address = fbrb_pkg::ADDR_W'(
               ($urandom_range(0, 1) ? $urandom_range(0, 31) : $urandom_range(0, 255))
               & ~((1 << sz) - 1));
         end else begin
            // noise: any opcode and size, around window edges or anywhere up to 0x17ffff
            a.opcode = 2'($urandom_range(0, 3));
            a.size_log2 = 2'($urandom_range(0, 3));
            if ($urandom_range(0, 1)) begin
               a.address = fbrb_pkg::ADDR_W'($urandom_range(0, 21'h17ffff));
            end else begin
               case ($urandom_range(0, 6))
                  0: boundary = 'h0f8;
                  1: boundary = 'h2ffc;
                  2: boundary = 'h30fc;
                  3: boundary = 'h3100;
                  4: boundary = 'h3ffc;
                  5: boundary = 'h43fc;
                  default: boundary = 'h4400;
               endcase
               a.address = fbrb_pkg::ADDR_W'(boundary + $urandom_range(0, 7));
            end
         end
         idle = 0;
         if (n < RANDOM_ITEMS - CALM_TAIL && $urandom_range(0, 3) == 0)
            idle = $urandom_range(1, 8);
         if (n == RANDOM_ITEMS / 2) begin
            // drain the pipeline completely before going on
            @(negedge clock);
            start <= 1'b0;
            while (bank_responses_due.size() != 0)
               @(negedge clock);
         end
         send_access(a, 1'b0, '0, idle);
      end

      @(negedge clock);
      start <= 1'b0;
      while (bank_responses_due.size() != 0)
         @(posedge clock);
      repeat (4)
         @(posedge clock);
      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
